FILE: design/crt_congruence_merger_defines.svh
// Assertion macros for the congruence merger RTL.
`ifndef CRT_CONGRUENCE_MERGER_DEFINES_SVH
`define CRT_CONGRUENCE_MERGER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crt assertion failed");

// Next-cycle implication, disabled during reset.
`define CRT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crt assertion failed");

`endif

FILE: design/crt_pkg.sv
// Shared constants, step codes and control structs for the congruence merger.
`default_nettype none
package crt_pkg;
    localparam int VB = 63;
    localparam int CW = $clog2(VB + 1);
    localparam int DATA_W = ((2 * VB + 7) / 8) * 8;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOSOL = 2'd1;
    localparam logic [1:0] STAT_OVF   = 2'd2;

    // datapath steps
    localparam logic [3:0] ST_C  = 4'd0;
    localparam logic [3:0] ST_G  = 4'd1;
    localparam logic [3:0] ST_CG = 4'd2;
    localparam logic [3:0] ST_AG = 4'd3;
    localparam logic [3:0] ST_M  = 4'd4;
    localparam logic [3:0] ST_OV = 4'd5;
    localparam logic [3:0] ST_DF = 4'd6;
    localparam logic [3:0] ST_Q  = 4'd7;
    localparam logic [3:0] ST_U  = 4'd8;
    localparam logic [3:0] ST_U2 = 4'd9;
    localparam logic [3:0] ST_E  = 4'd10;
    localparam logic [3:0] ST_QM = 4'd11;
    localparam logic [3:0] ST_P  = 4'd12;
    localparam logic [3:0] ST_T  = 4'd13;
    localparam logic [3:0] ST_B  = 4'd14;
    localparam logic [3:0] ST_BM = 4'd15;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       write;
        logic       out;
        logic [3:0] step;
    } crt_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
        logic y_zero;
        logic st_ok;
        logic m_one;
        logic out_full;
    } crt_stat_t;
endpackage
`default_nettype wire

FILE: design/crt_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module crt_div
    import crt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [VB-1:0] num,
    input  wire logic [VB-1:0] den,
    output logic               busy,
    output logic [VB-1:0]      quot,
    output logic [VB-1:0]      rem
);
    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [VB-1:0] n_reg;
    logic [VB-1:0] r_reg;
    logic [VB-1:0] dv_reg;
    logic [VB:0]   rr;
    logic          ge;
    logic [VB:0]   rd;

    assign rr = {r_reg, n_reg[VB-1]};
    assign ge = rr >= {1'b0, dv_reg};
    assign rd = rr - {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(VB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg  <= num;
            r_reg  <= '0;
            dv_reg <= den;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[VB-2:0], ge};
            r_reg <= ge ? rd[VB-1:0] : rr[VB-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = n_reg;
    assign rem  = r_reg;
endmodule
`default_nettype wire

FILE: design/crt_mul.sv
// Shift-and-add multiplier, plain or reduced modulo md, one bit per cycle.
`default_nettype none
module crt_mul
    import crt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          modular,
    input  wire logic [VB-1:0] a,
    input  wire logic [VB-1:0] b,
    input  wire logic [VB-1:0] md,
    output logic               busy,
    output logic [VB-1:0]      prod
);
    logic          busy_reg;
    logic          mode_reg;
    logic [VB-1:0] acc_reg;
    logic [VB-1:0] ma_reg;
    logic [VB-1:0] mb_reg;
    logic [VB-1:0] md_reg;
    logic [VB-1:0] acc_next;
    logic [VB-1:0] ma_next;

    function automatic logic [VB-1:0] add_mod(input logic [VB-1:0] x,
                                             input logic [VB-1:0] y,
                                             input logic [VB-1:0] m);
        logic [VB:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[VB-1:0];
    endfunction

    always_comb
    begin
        if (mode_reg)
        begin
            acc_next = add_mod(acc_reg, ma_reg, md_reg);
            ma_next  = add_mod(ma_reg, ma_reg, md_reg);
        end
        else
        begin
            acc_next = acc_reg + ma_reg;
            ma_next  = {ma_reg[VB-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (busy_reg && mb_reg == '0)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= modular;
            acc_reg  <= '0;
            ma_reg   <= a;
            mb_reg   <= b;
            md_reg   <= md;
        end
        else if (busy_reg && mb_reg != '0)
        begin
            if (mb_reg[0])
                acc_reg <= acc_next;
            ma_reg <= ma_next;
            mb_reg <= {1'b0, mb_reg[VB-1:1]};
        end
    end

    assign busy = busy_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

FILE: design/crt_dp.sv
// Datapath: running state, work registers, divider, multiplier, output register.
`default_nettype none
`include "crt_congruence_merger_defines.svh"
module crt_dp
    import crt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire crt_cmd_t      cmd,
    output crt_stat_t          stat,
    input  wire logic          in_first,
    input  wire logic [VB-1:0] in_modulus,
    input  wire logic [VB-1:0] in_residue,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [VB-1:0]      out_solution,
    output logic [VB-1:0]      out_modulus,
    output logic [1:0]         out_status
);
    logic [VB-1:0] a_reg, b_reg, c_reg, d_reg, g_reg, m_reg;
    logic [VB-1:0] x_reg, y_reg, s0_reg, s1_reg, tmp_reg, qv_reg, res_reg;
    logic [1:0]    st_reg;
    logic          ov_reg;
    logic [VB-1:0] sol_reg, cm_reg;
    logic [1:0]    ost_reg;

    logic [VB-1:0] dn, dd, quot, rem, ma, mb, prod, diff;
    logic          is_mul, modular, div_busy, mul_busy;

    assign diff = (c_reg >= a_reg) ? c_reg - a_reg : a_reg - c_reg;
    assign is_mul = (cmd.step == ST_P) || (cmd.step == ST_T) ||
                    (cmd.step == ST_B) || (cmd.step == ST_BM);

    always_comb
    begin
        dn = x_reg;
        dd = y_reg;
        case (cmd.step)
            ST_C:  begin dn = res_reg; dd = d_reg; end
            ST_CG: begin dn = c_reg;   dd = g_reg; end
            ST_AG: begin dn = a_reg;   dd = g_reg; end
            ST_M:  begin dn = d_reg;   dd = g_reg; end
            ST_OV: begin dn = '1;      dd = m_reg; end
            ST_DF: begin dn = diff;    dd = g_reg; end
            ST_Q:  begin dn = tmp_reg; dd = m_reg; end
            ST_U:  begin dn = b_reg;   dd = g_reg; end
            ST_U2: begin dn = tmp_reg; dd = m_reg; end
            ST_QM: begin dn = tmp_reg; dd = m_reg; end
            default: begin dn = x_reg; dd = y_reg; end
        endcase
    end

    always_comb
    begin
        ma = b_reg;
        mb = m_reg;
        modular = 1'b0;
        case (cmd.step)
            ST_P:  begin ma = tmp_reg; mb = s1_reg;  modular = 1'b1; end
            ST_T:  begin ma = qv_reg;  mb = s0_reg;  modular = 1'b1; end
            ST_B:  begin ma = b_reg;   mb = tmp_reg; modular = 1'b0; end
            default: begin ma = b_reg; mb = m_reg;   modular = 1'b0; end
        endcase
    end

    crt_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.start && !is_mul),
        .num  (dn),
        .den  (dd),
        .busy (div_busy),
        .quot (quot),
        .rem  (rem)
    );

    crt_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start && is_mul),
        .modular(modular),
        .a      (ma),
        .b      (mb),
        .md     (m_reg),
        .busy   (mul_busy),
        .prod   (prod)
    );

    // running state and sticky status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= '0;
            b_reg  <= VB'(1);
            st_reg <= STAT_OK;
        end
        else if (cmd.load)
        begin
            if (in_first)
            begin
                a_reg  <= '0;
                b_reg  <= VB'(1);
                st_reg <= STAT_OK;
            end
        end
        else if (cmd.write)
        begin
            case (cmd.step)
                ST_AG: if (rem != tmp_reg) st_reg <= STAT_NOSOL;
                ST_OV: if (b_reg > quot) st_reg <= STAT_OVF;
                ST_B:  a_reg <= a_reg + prod;
                ST_BM: b_reg <= prod;
                default: st_reg <= st_reg;
            endcase
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg   <= (in_modulus == '0) ? VB'(1) : in_modulus;
            res_reg <= in_residue;
        end
        else if (cmd.write)
        begin
            case (cmd.step)
                ST_C:
                begin
                    c_reg <= rem;
                    x_reg <= b_reg;
                    y_reg <= d_reg;
                end
                ST_G:
                begin
                    x_reg <= y_reg;
                    g_reg <= y_reg;
                    y_reg <= rem;
                end
                ST_CG: tmp_reg <= rem;
                ST_M:  m_reg <= quot;
                ST_DF: tmp_reg <= quot;
                ST_Q:  qv_reg <= (c_reg < a_reg && rem != '0) ? m_reg - rem : rem;
                ST_U:  tmp_reg <= quot;
                ST_U2:
                begin
                    x_reg  <= m_reg;
                    y_reg  <= rem;
                    s0_reg <= '0;
                    s1_reg <= VB'(1);
                end
                ST_E:
                begin
                    x_reg   <= y_reg;
                    y_reg   <= rem;
                    tmp_reg <= quot;
                end
                ST_QM: tmp_reg <= rem;
                ST_P:
                begin
                    s0_reg <= s1_reg;
                    s1_reg <= (s0_reg >= prod) ? s0_reg - prod : s0_reg + (m_reg - prod);
                end
                ST_T:  tmp_reg <= prod;
                default: tmp_reg <= tmp_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out)
        begin
            sol_reg <= (st_reg == STAT_OK) ? a_reg : '0;
            cm_reg  <= (st_reg == STAT_OK) ? b_reg : VB'(1);
            ost_reg <= st_reg;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.mul_busy = mul_busy;
    assign stat.y_zero   = (y_reg == '0);
    assign stat.st_ok    = (st_reg == STAT_OK);
    assign stat.m_one    = (m_reg == VB'(1));
    assign stat.out_full = ov_reg && !out_ready;

    assign out_valid    = ov_reg;
    assign out_solution = sol_reg;
    assign out_modulus  = cm_reg;
    assign out_status   = ost_reg;

    `CRT_ASSERT_IMP(a_start_idle, cmd.start, !div_busy && !mul_busy)
    `CRT_ASSERT_IMP(a_one_unit, mul_busy, !div_busy)
    `CRT_ASSERT_IMP(a_out_free, cmd.out, !(ov_reg && !out_ready))
    `CRT_ASSERT_NXT(a_sticky, st_reg != STAT_OK && !cmd.load, st_reg == $past(st_reg))
endmodule
`default_nettype wire

FILE: design/crt_ctrl.sv
// Controller: sequences the merge steps over the shared divider and multiplier.
`default_nettype none
module crt_ctrl
    import crt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire crt_stat_t stat,
    output crt_cmd_t       cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GO   = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] succ;

    always_comb
    begin
        case (step_reg)
            ST_C:    succ = ST_G;
            ST_G:    succ = ST_G;
            ST_CG:   succ = ST_AG;
            ST_AG:   succ = ST_M;
            ST_M:    succ = ST_OV;
            ST_OV:   succ = ST_DF;
            ST_DF:   succ = ST_Q;
            ST_Q:    succ = ST_U;
            ST_U:    succ = ST_U2;
            ST_U2:   succ = ST_E;
            ST_E:    succ = ST_QM;
            ST_QM:   succ = ST_P;
            ST_P:    succ = ST_E;
            ST_T:    succ = ST_B;
            ST_B:    succ = ST_BM;
            default: succ = ST_BM;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = ST_C;
                    state_next = S_GO;
                end
            end
            S_GO:
            begin
                if ((step_reg == ST_M && !stat.st_ok) ||
                    (step_reg == ST_DF && (!stat.st_ok || stat.m_one)))
                    state_next = S_OUT;
                else if (step_reg == ST_G && stat.y_zero)
                    step_next = ST_CG;
                else if (step_reg == ST_E && stat.y_zero)
                    step_next = ST_T;
                else if (step_reg == ST_C && !stat.st_ok)
                    state_next = S_OUT;
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!stat.div_busy && !stat.mul_busy)
                begin
                    cmd.write  = 1'b1;
                    step_next  = succ;
                    state_next = (step_reg == ST_BM) ? S_OUT : S_GO;
                end
            end
            S_OUT:
            begin
                if (!stat.out_full)
                begin
                    cmd.out    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_C;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule
`default_nettype wire

FILE: design/crt_congruence_merger.sv
// Top level: generalized CRT merger of streamed congruences.
// Usage:
//   Input words on s_*: tuser carries the restart flag, tdata carries modulus
//   and residue. A set restart flag starts over at 0 mod 1 with status ok.
//   One output word on m_* per input word: running solution, lcm of the
//   moduli, and status in tuser (0 ok, 1 no solution, 2 overflow; sticky
//   until a restart, with solution 0 and modulus 1 shown while not ok).
//   One word is processed at a time: s_tready is high only while idle.
//   Each divide or multiply step is a start, the shift steps of the divider or
//   multiplier, and a write-back; the gcd loop and the extended Euclid loop (one
//   divide, one reduce and one modular multiply per iteration) each run up
//   to about 90 iterations, so a word finishes soonest when the status is
//   already sticky and takes longest for large coprime moduli.
//   The result sits in an output register; while it is not taken the next
//   word may be accepted and computed, and waits before its own result
//   is written until m_tready drains the previous one.
//   Reset empties the output register and sets the state to 0 mod 1, ok.
`default_nettype none
module crt_congruence_merger
    import crt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // modulus, residue, zero pad
    input  wire logic              s_tuser,   // first
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // solution, combined_modulus, zero pad
    output logic [1:0]             m_tuser    // status
);
    crt_cmd_t      cmd;
    crt_stat_t     stat;
    logic [VB-1:0] sol, cm;

    crt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    crt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_first    (s_tuser),
        .in_modulus  (s_tdata[VB-1:0]),
        .in_residue  (s_tdata[2*VB-1:VB]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_solution(sol),
        .out_modulus (cm),
        .out_status  (m_tuser)
    );

    assign m_tdata = {{(DATA_W - 2 * VB){1'b0}}, cm, sol};
endmodule
`default_nettype wire

FILE: dv/crt_congruence_merger_test.sv
// Testbench for the congruence merger: random and directed congruences vs a predictor.
`timescale 1ns / 100ps
`default_nettype none
module crt_congruence_merger_test
    import crt_pkg::*;
();

    localparam logic [62:0] VMAX = {63{1'b1}};

    typedef struct packed {
        logic [62:0] sol;
        logic [62:0] lcm;
        logic [1:0]  status;
    } crt_result_t;

    // modular helpers, operands below m < 2^63
    function automatic logic [62:0] mod_mul(logic [62:0] a, logic [62:0] b, logic [62:0] m);
        logic [125:0] p;
        p = a * b;
        return 63'(p % m);
    endfunction

    function automatic logic [62:0] gcd63(logic [62:0] a, logic [62:0] b);
        logic [62:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [62:0] inverse_mod(logic [62:0] u, logic [62:0] m);
        logic [62:0] r0, r1, r2, s0, s1, s2, q, p;
        r0 = m;
        r1 = u % m;
        s0 = 0;
        s1 = 1;
        while (r1 != 0)
        begin
            q = r0 / r1;
            r2 = r0 - q * r1;
            p = mod_mul(q % m, s1, m);
            s2 = (s0 >= p) ? s0 - p : s0 + (m - p);
            r0 = r1; r1 = r2;
            s0 = s1; s1 = s2;
        end
        return s0;
    endfunction

    class crt_scoreboard;
        logic [62:0] run_sol, run_mod;
        logic [1:0]  sticky;
        crt_result_t pending[$];
        int          errors;
        int          checked;
        int          n_nosol, n_ovf;

        function void restart();
            run_sol = 0;
            run_mod = 1;
            sticky = STAT_OK;
        endfunction

        function void note_congruence(logic first, logic [62:0] d, logic [62:0] r);
            logic [62:0] c, a, b, g, m, q, t;
            crt_result_t res;
            if (first)
                restart();
            if (d == 0)
                d = 1;
            c = r % d;
            if (sticky == STAT_OK)
            begin
                a = run_sol;
                b = run_mod;
                g = gcd63(b, d);
                if ((c % g) != (a % g))
                    sticky = STAT_NOSOL;
                else
                begin
                    m = d / g;
                    if (b > VMAX / m)
                        sticky = STAT_OVF;
                    else
                    begin
                        t = 0;
                        if (m > 1)
                        begin
                            if (c >= a)
                                q = ((c - a) / g) % m;
                            else
                            begin
                                q = ((a - c) / g) % m;
                                q = (q == 0) ? 0 : m - q;
                            end
                            t = mod_mul(q, inverse_mod((b / g) % m, m), m);
                        end
                        run_sol = a + b * t;
                        run_mod = b * m;
                    end
                end
            end
            res.status = sticky;
            res.sol = (sticky == STAT_OK) ? run_sol : 63'd0;
            res.lcm = (sticky == STAT_OK) ? run_mod : 63'd1;
            if (sticky == STAT_NOSOL) n_nosol++;
            if (sticky == STAT_OVF) n_ovf++;
            pending.push_back(res);
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic [1:0] status);
            crt_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("unexpected output word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[62:0] !== e.sol)
            begin
                $error("solution: expected %0d, got %0d", e.sol, data[62:0]);
                errors++;
            end
            if (data[125:63] !== e.lcm)
            begin
                $error("combined_modulus: expected %0d, got %0d", e.lcm, data[125:63]);
                errors++;
            end
            if (data[DATA_W-1:126] !== '0)
            begin
                $error("pad: expected 0, got %0h", data[DATA_W-1:126]);
                errors++;
            end
            if (status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;

    crt_scoreboard sb;
    bit            calm;
    longint        cycles;

    crt_congruence_merger u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()} >> 1);
    endfunction

    // small modulus with random shape, occasionally large
    function automatic logic [62:0] pick_modulus();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return rand63();
        if (k == 1)
            return rand63() >> $urandom_range(1, 62);
        return 63'($urandom_range(1, 60));
    endfunction

    // called at a falling edge; tvalid stays up between words unless idling
    task automatic send_word(logic first, logic [62:0] d, logic [62:0] r);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {{(DATA_W-126){1'b0}}, r, d};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_congruence(first, d, r);
        @(negedge clk);
    endtask

    // sink side: random stalls, checks on every accepted word
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd20000000)
        begin
            $display("crt_congruence_merger: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [62:0] x, d;
        int          n;
        sb = new();
        sb.restart();
        cycles = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: coprime chain, zero modulus, extremes, conflict, overflow
        send_word(1'b0, 63'd3, 63'd2);
        send_word(1'b0, 63'd5, 63'd3);
        send_word(1'b0, 63'd7, 63'd2);
        send_word(1'b0, 63'd0, VMAX);
        send_word(1'b0, 63'd6, 63'd5);          // agrees mod 3: gcd lift
        send_word(1'b0, 63'd4, 63'd1);          // agrees mod 2: gcd lift
        send_word(1'b0, 63'd9, 63'd4);          // conflict mod 3
        send_word(1'b1, VMAX, VMAX);
        send_word(1'b0, VMAX, 63'd0);
        send_word(1'b0, 63'd2, 63'd0);          // overflow
        send_word(1'b0, 63'd3, 63'd1);
        send_word(1'b1, 63'd1, 63'd0);
        send_word(1'b1, VMAX - 1, VMAX - 2);
        send_word(1'b0, 63'h2aaaaaaaaaaaaaab, 63'h5555555555555555);
        send_word(1'b1, 63'd1 << 62, 63'h7fffffff00000000);
        send_word(1'b0, 63'd12, 63'd8);
        send_word(1'b1, 63'd4, 63'd3);
        send_word(1'b0, 63'd6, 63'd1);
        send_word(1'b0, 63'd10, 63'd7);

        // random: chains built around a hidden target so most merges agree
        n = 0;
        while (n < 130)
        begin
            calm = (n >= 50 && n < 80);
            x = rand63();
            send_word(1'b1, pick_modulus(), x);
            n++;
            repeat ($urandom_range(1, 6))
            begin
                d = pick_modulus();
                if ($urandom_range(0, 9) == 0)
                    send_word(1'b0, d, rand63());
                else
                    send_word(1'b0, d, x % (d == 0 ? 63'd1 : d));
                n++;
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Merged %0d congruences: %0d results with no solution, %0d with overflow.",
                 sb.checked, sb.n_nosol, sb.n_ovf);
        if (sb.errors == 0)
            $display("crt_congruence_merger: match");
        else
            $display("crt_congruence_merger: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
